[hdl/gls_pkg.sv]
// Shared types and constants for the grid line-of-sight unit.
`timescale 1ns / 1ps

package gls_pkg;

  // Default map side in cells.
  localparam int MAX_SIDE_DEF = 256;

  // Raw occupancy value that marks a cell occupied.
  localparam logic [7:0] OCC_VALUE = 8'd100;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_CLEAR   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_SAME    = 3'd3;
  localparam logic [2:0] ST_OFFMAP  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CPM    = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] CPM_RESET    = 16'd5120;
  localparam logic [8:0]  WIDTH_RESET  = 9'd256;
  localparam logic [8:0]  HEIGHT_RESET = 9'd256;

  // Datapath widths, fixed by the Q11.12 inputs and the Q8.8 scale.
  localparam int COORD_W  = 24;              // raw coordinate
  localparam int DIFF_W   = COORD_W + 1;     // raw coordinate difference
  localparam int FRAC_W   = 20;              // fraction bits of cell positions
  localparam int POS_W    = 42;              // Q.20 positions and deltas
  localparam int CNT_W    = 21;              // step count
  localparam int DIV_BITS = 18;              // quotient bits of one step division
  localparam int DEN_W    = CNT_W + 4 + DIV_BITS;
  localparam int STEP_W   = DIV_BITS + 1;    // signed Q.16 step
  localparam int CELL_W   = POS_W - FRAC_W;  // signed cell coordinate

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_CNT,
    S_DIVX,
    S_DIVY,
    S_WALK,
    S_LOOK,
    S_PUT
  } state_t;

endpackage

[hdl/grid_line_of_sight_unit.sv]
// Grid line-of-sight unit: occupancy bitmap, shared scale/divide unit and walk sequencer.
`timescale 1ns / 1ps

// Each accepted request gives exactly one result. A load, or a query with equal end
// points, goes straight to the result stage. Any other query has its coordinates
// scaled on one shared multiplier, then one shared compare-and-subtract unit
// produces the two step sizes, and each of up to N sampled points, where N is the
// floor of the larger coordinate delta in cells, is checked by a registered bitmap
// read. One request is worked on at a time; the next request is taken once the
// result has moved into the output register. After reset the bitmap is swept
// clear, one cell a cycle, over all MAX_SIDE*MAX_SIDE cells (65536 at the default
// size); configuration writes are taken during that sweep.
module grid_line_of_sight_unit #(
  parameter int MAX_SIDE = gls_pkg::MAX_SIDE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // From bit 0: cell_index[15:0], cell_value[7:0], x_start[23:0], y_start[23:0],
  // x_end[23:0], y_end[23:0].
  input  logic [119:0] s_tdata,
  // Bit 0: req_type.
  input  logic         s_tuser,
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0: has_los, status[2:0], then zero padding.
  output logic [7:0]   m_tdata
);

  import gls_pkg::*;

  localparam int MAP_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int XB        = $clog2(MAX_SIDE);
  localparam int SW        = $clog2(MAX_SIDE + 1);

  // Request fields.
  logic                     req_type;
  logic [15:0]              cell_index;
  logic signed [7:0]        cell_value;
  logic signed [COORD_W-1:0] x_start, y_start, x_end, y_end;

  assign req_type   = s_tuser;
  assign cell_index = s_tdata[15:0];
  assign cell_value = s_tdata[23:16];
  assign x_start    = s_tdata[47:24];
  assign y_start    = s_tdata[71:48];
  assign x_end      = s_tdata[95:72];
  assign y_end      = s_tdata[119:96];

  // Configuration registers.
  logic [15:0] cells_per_meter;
  logic [8:0]  grid_width;
  logic [8:0]  grid_height;

  // Control state.
  state_t         state, state_next;
  logic [AW-1:0]  clr_cnt;
  logic [1:0]     mul_cnt;
  logic [4:0]     div_cnt;

  // Query payload.
  logic signed [COORD_W-1:0] xs, ys;
  logic signed [DIFF_W-1:0]  ddx, ddy;
  logic signed [POS_W-1:0]   xs_c, ys_c, dx_c, dy_c;
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic signed [STEP_W-1:0]  step_x, step_y;
  logic [CNT_W-1:0]          walk_left;
  logic [CNT_W-1:0]          count;
  logic [POS_W-1:0]          div_rem;
  logic [DEN_W-1:0]          div_den;
  logic [DIV_BITS-1:0]       div_q;
  logic                      res_los;
  logic [2:0]                res_status;

  // Bitmap.
  logic          occ_mem [MAP_CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] rd_addr;
  logic          mem_rdata;

  logic accept;
  logic out_free;
  logic same_point;
  logic [31:0] ld_idx;
  logic ld_in_range;

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign same_point = (x_start == x_end) && (y_start == y_end);
  assign ld_idx     = 32'(cell_index);
  assign ld_in_range = ld_idx < 32'(MAP_CELLS);

  // Effective map size, clamped to the bitmap side.
  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    if (32'(grid_width) > 32'(MAX_SIDE)) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(grid_width);
    end
    if (32'(grid_height) > 32'(MAX_SIDE)) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(grid_height);
    end
  end

  // Shared multiplier: scales one coordinate or difference per cycle.
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [POS_W-1:0]  mul_p;

  always_comb begin
    case (mul_cnt)
      2'd0:    mul_a = DIFF_W'(xs);
      2'd1:    mul_a = DIFF_W'(ys);
      2'd2:    mul_a = ddx;
      default: mul_a = ddy;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, cells_per_meter});

  // Step count: floor of the larger absolute delta in cells.
  logic [POS_W-1:0] adx, ady, amax;
  logic [CNT_W-1:0] count_c;

  assign adx     = dx_c[POS_W-1] ? POS_W'(-dx_c) : POS_W'(dx_c);
  assign ady     = dy_c[POS_W-1] ? POS_W'(-dy_c) : POS_W'(dy_c);
  assign amax    = (adx > ady) ? adx : ady;
  assign count_c = amax[FRAC_W+CNT_W-1:FRAC_W];

  // Shared compare-and-subtract unit: one quotient bit per cycle.
  logic                div_ge;
  logic [POS_W-1:0]    div_rem_sub;
  logic [DIV_BITS-1:0] div_q_next;
  logic [DEN_W-1:0]    den_init;
  logic                div_last;

  assign den_init    = DEN_W'({count_c, 4'b0000}) << (DIV_BITS - 1);
  assign div_ge      = DEN_W'(div_rem) >= div_den;
  assign div_rem_sub = div_rem - POS_W'(div_den);
  assign div_q_next  = {div_q[DIV_BITS-2:0], div_ge};
  assign div_last    = div_cnt == 5'(DIV_BITS - 1);

  // Cell of the current sample, truncated toward zero.
  logic signed [CELL_W-1:0] cx, cy;
  logic off_map;
  logic [XB-1:0] cx_lo, cy_lo;
  logic [2*SW-1:0] rd_prod;

  always_comb begin
    cx = pos_x[POS_W-1:FRAC_W];
    if (pos_x[POS_W-1] && (|pos_x[FRAC_W-1:0])) begin
      cx = cx + CELL_W'(1);
    end
    cy = pos_y[POS_W-1:FRAC_W];
    if (pos_y[POS_W-1] && (|pos_y[FRAC_W-1:0])) begin
      cy = cy + CELL_W'(1);
    end
  end

  assign off_map = cx[CELL_W-1] || cy[CELL_W-1] ||
                   (cx[CELL_W-2:0] >= (CELL_W-1)'(w_eff)) ||
                   (cy[CELL_W-2:0] >= (CELL_W-1)'(h_eff));
  assign cx_lo   = cx[XB-1:0];
  assign cy_lo   = cy[XB-1:0];
  assign rd_prod = (2*SW)'(cy_lo) * (2*SW)'(w_eff);
  assign rd_addr = AW'(rd_prod + (2*SW)'(cx_lo));

  logic clr_done;
  logic walk_last;

  assign clr_done  = clr_cnt == AW'(MAP_CELLS - 1);
  assign walk_last = walk_left == CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_LOAD || same_point) state_next = S_PUT;
          else state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_cnt == 2'd3) state_next = S_CNT;
      end
      S_CNT: begin
        if (count_c == '0) state_next = S_PUT;
        else state_next = S_DIVX;
      end
      S_DIVX: begin
        if (div_last) state_next = S_DIVY;
      end
      S_DIVY: begin
        if (div_last) state_next = S_WALK;
      end
      S_WALK: begin
        if (off_map) state_next = S_PUT;
        else state_next = S_LOOK;
      end
      S_LOOK: begin
        if (mem_rdata || walk_last) state_next = S_PUT;
        else state_next = S_WALK;
      end
      S_PUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  // Handshake and bitmap write port.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        s_tready  = 1'b1;
        mem_we    = s_tvalid && (req_type == REQ_LOAD) && ld_in_range;
        mem_waddr = ld_idx[AW-1:0];
        mem_wdata = cell_value == $signed(OCC_VALUE);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Bitmap storage with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= occ_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      clr_cnt         <= '0;
      mul_cnt         <= '0;
      div_cnt         <= '0;
      m_tvalid        <= 1'b0;
      cells_per_meter <= CPM_RESET;
      grid_width      <= WIDTH_RESET;
      grid_height     <= HEIGHT_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_cnt <= clr_cnt + AW'(1);
      if (state == S_MUL) mul_cnt <= mul_cnt + 2'd1;
      else mul_cnt <= '0;
      if (state == S_DIVX || state == S_DIVY) begin
        div_cnt <= div_last ? 5'd0 : div_cnt + 5'd1;
      end else begin
        div_cnt <= '0;
      end
      if (state == S_PUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      // Register writes.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CPM:    cells_per_meter <= cfg_data;
          CFG_WIDTH:  grid_width      <= cfg_data[8:0];
          CFG_HEIGHT: grid_height     <= cfg_data[8:0];
          default:    ;
        endcase
      end
    end
  end

  // Query datapath and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        xs  <= x_start;
        ys  <= y_start;
        ddx <= DIFF_W'(x_end) - DIFF_W'(x_start);
        ddy <= DIFF_W'(y_end) - DIFF_W'(y_start);
        if (req_type == REQ_LOAD) begin
          res_los    <= 1'b0;
          res_status <= ST_LOAD;
        end else begin
          res_los    <= 1'b0;
          res_status <= ST_SAME;
        end
      end
      S_MUL: begin
        case (mul_cnt)
          2'd0:    xs_c <= mul_p;
          2'd1:    ys_c <= mul_p;
          2'd2:    dx_c <= mul_p;
          default: dy_c <= mul_p;
        endcase
      end
      S_CNT: begin
        count      <= count_c;
        walk_left  <= count_c;
        div_rem    <= adx;
        div_den    <= den_init;
        div_q      <= '0;
        res_los    <= 1'b1;
        res_status <= ST_CLEAR;
      end
      S_DIVX: begin
        if (div_last) begin
          step_x  <= dx_c[POS_W-1] ? -$signed({1'b0, div_q_next}) : $signed({1'b0, div_q_next});
          div_rem <= ady;
          div_den <= DEN_W'({count, 4'b0000}) << (DIV_BITS - 1);
          div_q   <= '0;
        end else begin
          div_rem <= div_ge ? div_rem_sub : div_rem;
          div_den <= div_den >> 1;
          div_q   <= div_q_next;
        end
      end
      S_DIVY: begin
        if (div_last) begin
          step_y <= dy_c[POS_W-1] ? -$signed({1'b0, div_q_next}) : $signed({1'b0, div_q_next});
          pos_x  <= xs_c;
          pos_y  <= ys_c;
        end else begin
          div_rem <= div_ge ? div_rem_sub : div_rem;
          div_den <= div_den >> 1;
          div_q   <= div_q_next;
        end
      end
      S_WALK: begin
        if (off_map) begin
          res_los    <= 1'b0;
          res_status <= ST_OFFMAP;
        end
      end
      S_LOOK: begin
        if (mem_rdata) begin
          res_los    <= 1'b0;
          res_status <= ST_BLOCKED;
        end
        // Advance to the next sample; steps are signed Q.16, positions Q.20.
        pos_x     <= pos_x + POS_W'($signed({step_x, 4'b0000}));
        pos_y     <= pos_y + POS_W'($signed({step_y, 4'b0000}));
        walk_left <= walk_left - CNT_W'(1);
      end
      S_PUT: begin
        if (out_free) m_tdata <= {4'b0000, res_status, res_los};
      end
      default: begin
        res_los <= res_los;
      end
    endcase
  end

  // The bitmap is only written by the clearing sweep or a load request.
  a_mem_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || state == S_IDLE))
    else $error("bitmap written outside clear sweep or load");

  // A waiting result keeps the sequencer from taking new work.
  a_put_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && m_tvalid && !m_tready) |=> (state == S_PUT))
    else $error("sequencer left result stage with output still full");

  // Line of sight is reported only together with the clear status.
  a_los_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == ST_CLEAR))
    else $error("has_los set with a status other than clear");

  // A bitmap lookup always belongs to a sample that is still due.
  a_walk_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> (walk_left != '0))
    else $error("bitmap lookup with no samples left");

endmodule

[sim/gls_result_checker.sv]
// Result checker for the grid line-of-sight unit: mirrors the map and registers, predicts and compares.
`timescale 1ns / 1ps

module gls_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // From bit 0: cell_index[15:0], cell_value[7:0], x_start, y_start, x_end, y_end.
  input  logic [119:0] s_tdata,
  // Bit 0: req_type.
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0: has_los, status[2:0], then zero padding.
  input  logic [7:0]   m_tdata,
  output int           outstanding,
  output int           errors
);
  import gls_pkg::*;

  localparam int     SIDE      = MAX_SIDE_DEF;
  localparam int     MAP_CELLS = SIDE * SIDE;
  localparam longint CELL_ONE  = 64'sd1 << FRAC_W;

  typedef struct packed {
    logic [2:0] status;
    logic       has_los;
  } los_result_t;

  // Mirror of the block's bitmap and registers.
  bit [MAP_CELLS-1:0] occupied;
  logic [15:0]        scale_q8;
  logic [8:0]         width_cells;
  logic [8:0]         height_cells;

  // Results predicted for accepted requests, oldest first.
  los_result_t pending_results[$];
  int          mismatch_count = 0;

  initial begin
    outstanding = 0;
    errors      = 0;
  end

  // Walk the segment in equal Q.20 steps and report the first occupied or off-map sample.
  function automatic los_result_t sight_outcome(input logic [23:0] xs_raw, input logic [23:0] ys_raw,
                                                input logic [23:0] xe_raw, input logic [23:0] ye_raw);
    longint xs, ys, xe, ye, k;
    longint xs_q20, ys_q20, dx, dy, adx, ady, steps, step_x, step_y;
    longint w_eff, h_eff, cx, cy;
    los_result_t r;
    xs = $signed(xs_raw);
    ys = $signed(ys_raw);
    xe = $signed(xe_raw);
    ye = $signed(ye_raw);
    r.has_los = 1'b0;
    r.status  = ST_SAME;
    if (xs == xe && ys == ye) return r;
    k      = scale_q8;
    xs_q20 = xs * k;
    ys_q20 = ys * k;
    dx     = (xe - xs) * k;
    dy     = (ye - ys) * k;
    adx    = (dx < 0) ? -dx : dx;
    ady    = (dy < 0) ? -dy : dy;
    steps  = ((adx > ady) ? adx : ady) / CELL_ONE;
    r.has_los = 1'b1;
    r.status  = ST_CLEAR;
    if (steps == 0) return r;
    // Steps are truncated to Q.16 before the walk.
    step_x = (dx / (steps * 16)) * 16;
    step_y = (dy / (steps * 16)) * 16;
    w_eff  = (width_cells > SIDE) ? SIDE : width_cells;
    h_eff  = (height_cells > SIDE) ? SIDE : height_cells;
    for (longint i = 0; i < steps; i++) begin
      cx = (xs_q20 + step_x * i) / CELL_ONE;
      cy = (ys_q20 + step_y * i) / CELL_ONE;
      if (cx < 0 || cy < 0 || cx >= w_eff || cy >= h_eff) begin
        r.has_los = 1'b0;
        r.status  = ST_OFFMAP;
        return r;
      end
      if (occupied[cx + cy * w_eff]) begin
        r.has_los = 1'b0;
        r.status  = ST_BLOCKED;
        return r;
      end
    end
    return r;
  endfunction

  task automatic flag(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin : track
    los_result_t seen;
    los_result_t want;
    logic [15:0] load_index;
    if (rst) begin
      occupied     = '0;
      scale_q8     = CPM_RESET;
      width_cells  = WIDTH_RESET;
      height_cells = HEIGHT_RESET;
      pending_results.delete();
    end else begin
      // A delivered result is compared with the oldest prediction.
      if (m_tvalid && m_tready) begin
        seen.has_los = m_tdata[0];
        seen.status  = m_tdata[3:1];
        if (pending_results.size() == 0) begin
          flag($sformatf("result with no request pending: has_los=%0b status=%0d",
                         seen.has_los, seen.status));
        end else begin
          want = pending_results.pop_front();
          if (seen !== want)
            flag($sformatf("result mismatch: expected has_los=%0b status=%0d, got has_los=%b status=%0d",
                           want.has_los, want.status, seen.has_los, seen.status));
        end
      end
      // Register writes; the spare index is dropped.
      if (cfg_write) begin
        case (cfg_index)
          CFG_CPM:    scale_q8     = cfg_data;
          CFG_WIDTH:  width_cells  = cfg_data[8:0];
          CFG_HEIGHT: height_cells = cfg_data[8:0];
          default: ;
        endcase
      end
      // Each accepted request yields one predicted result.
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_LOAD) begin
          load_index = s_tdata[15:0];
          if (load_index < MAP_CELLS) occupied[load_index] = (s_tdata[23:16] == OCC_VALUE);
          want.has_los = 1'b0;
          want.status  = ST_LOAD;
        end else begin
          want = sight_outcome(s_tdata[47:24], s_tdata[71:48], s_tdata[95:72], s_tdata[119:96]);
        end
        pending_results = {pending_results, want};
      end
    end
    outstanding <= pending_results.size();
    errors      <= mismatch_count;
  end

endmodule

[sim/tb_grid_line_of_sight_unit.sv]
// Testbench top for the grid line-of-sight unit: clock, reset, register phases and request traffic.
`timescale 1ns / 1ps

module tb_grid_line_of_sight_unit;
  import gls_pkg::*;

  // Index past the three registers; the block must ignore writes to it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_write;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  int           outstanding;
  int           errors;

  // Register values in force, used only to shape the traffic.
  logic [15:0]  cur_cpm;
  logic [8:0]   cur_w;
  logic [8:0]   cur_h;
  int           wall_x;
  int           wall_y;
  bit           no_gaps;
  int           rx_hold = 0;
  bit           rx_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_line_of_sight_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  gls_result_checker los_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Idle length: mostly a few cycles, sometimes a long stretch.
  function automatic int idle_span();
    if ($urandom_range(99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  // Result side stalls at random, with occasional stretches of steady acceptance.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_steady && $urandom_range(5) == 0) rx_hold <= idle_span();
    end
    if ($urandom_range(249) == 0) rx_steady <= !rx_steady;
  end

  // Present one request and hold it until the handshake, then maybe idle.
  task automatic push_request(input logic kind, input logic [119:0] fields);
    int gap;
    s_tuser  <= kind;
    s_tdata  <= fields;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = (no_gaps || $urandom_range(1) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_cell(input logic [15:0] index, input logic [7:0] value);
    logic [119:0] fields;
    fields        = 120'({$urandom, $urandom, $urandom, $urandom});
    fields[23:0]  = {value, index};
    push_request(REQ_LOAD, fields);
  endtask

  task automatic ask_sight(input logic [23:0] xs, input logic [23:0] ys,
                           input logic [23:0] xe, input logic [23:0] ye);
    logic [119:0] fields;
    fields          = 120'({$urandom, $urandom, $urandom, $urandom});
    fields[119:24]  = {ye, xe, ys, xs};
    push_request(REQ_QUERY, fields);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] cpm, input logic [8:0] w, input logic [8:0] h);
    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_CPM, cpm);
    write_reg(CFG_WIDTH, {7'd0, w});
    write_reg(CFG_HEIGHT, {7'd0, h});
    cfg_write <= 1'b0;
    cur_cpm = cpm;
    cur_w   = w;
    cur_h   = h;
    wall_x  = $urandom_range(255);
    wall_y  = $urandom_range(255);
  endtask

  // Cell position in Q.8 cells to raw Q11.12 meters at the current scale, saturated.
  function automatic logic [23:0] cells_to_raw(input longint cq8);
    longint v;
    if (cur_cpm == 0) v = cq8 * 16;
    else v = (cq8 * 4096) / longint'(cur_cpm);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Mix of loads around a wall, well-formed walks, short and same-point queries, and noise.
  task automatic random_request();
    logic [119:0] fields;
    int           roll, w_eff, h_eff, x, y;
    longint       sx, sy, ex, ey;
    fields = 120'({$urandom, $urandom, $urandom, $urandom});
    roll   = $urandom_range(99);
    w_eff  = (cur_w == 0) ? 1 : ((cur_w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cur_w);
    h_eff  = (cur_h == 0) ? 1 : ((cur_h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cur_h);
    if (roll < 30) begin
      // Loads inside the map, many on one column or row so that walks get blocked.
      if (roll >= 9) begin
        x = $urandom_range(w_eff - 1);
        y = $urandom_range(h_eff - 1);
        if (roll < 18) x = wall_x % w_eff;
        else if (roll < 24) y = wall_y % h_eff;
        fields[15:0] = 16'(x + y * w_eff);
        if ($urandom_range(9) < 7) fields[23:16] = OCC_VALUE;
      end
      push_request(REQ_LOAD, fields);
    end else begin
      if (roll >= 40) begin
        sx = longint'($urandom_range((w_eff + 4) * 256)) - 512;
        sy = longint'($urandom_range((h_eff + 4) * 256)) - 512;
        if (roll < 50) begin
          ex = sx + longint'($urandom_range(600)) - 300;
          ey = sy + longint'($urandom_range(600)) - 300;
        end else if (roll < 57) begin
          ex = sx;
          ey = sy;
        end else begin
          ex = longint'($urandom_range((w_eff + 20) * 256)) - 2560;
          ey = longint'($urandom_range((h_eff + 20) * 256)) - 2560;
        end
        fields[119:24] = {cells_to_raw(ey), cells_to_raw(ex), cells_to_raw(sy), cells_to_raw(sx)};
      end
      push_request(REQ_QUERY, fields);
    end
  endtask

  initial begin
    int phase;
    int n;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_CPM;
    cfg_data  <= 16'd0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_LOAD;
    cur_cpm   = CPM_RESET;
    cur_w     = WIDTH_RESET;
    cur_h     = HEIGHT_RESET;
    wall_x    = 0;
    wall_y    = 0;
    no_gaps   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset scale of 20 cells per meter.
    load_cell(16'd2570, OCC_VALUE);           // cell (10,10) occupied
    load_cell(16'd0, 8'h80);                  // most negative raw value, free
    load_cell(16'hFFFF, OCC_VALUE);           // far corner occupied
    load_cell(16'd1, 8'h7F);
    load_cell(16'd2, 8'd99);                  // one below the occupied value
    load_cell(16'd3, 8'd101);
    load_cell(16'd5130, OCC_VALUE);           // (10,20) set, then freed again
    load_cell(16'd5130, 8'd0);
    ask_sight(24'd1000, 24'd2000, 24'd1000, 24'd2000);
    ask_sight(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    ask_sight(24'd2150, 24'd2150, 24'd2200, 24'd2150);        // under one cell: no samples
    ask_sight(24'd20, 24'd2150, 24'd4096, 24'd2150);          // runs into (10,10)
    ask_sight(24'd2150, 24'd0, 24'd2150, 24'd8192);           // vertical through (10,10)
    ask_sight(-24'sd4096, 24'd0, 24'd4096, 24'd0);            // starts left of the map
    ask_sight(24'd40000, 24'd100, 24'd60000, 24'd100);        // leaves past the right edge
    ask_sight(24'd0, 24'd20480, 24'd40960, 24'd20480);        // open row
    ask_sight(24'd0, 24'd4196, 24'd8192, 24'd4196);           // through the freed cell
    ask_sight(24'd49152, 24'd49152, 24'd52429, 24'd52429);    // diagonal into the corner
    ask_sight(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    ask_sight(24'h7FFFFF, 24'd0, 24'h800000, 24'd0);
    drain();

    // Random part over several register settings, extremes included.
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: configure(CPM_RESET, WIDTH_RESET, HEIGHT_RESET);
        1: configure(16'hFFFF, 9'd256, 9'd256);
        2: configure(16'd1, 9'd1, 9'd1);
        3: configure(16'd256, 9'd64, 9'd200);
        4: configure(16'd0, 9'd100, 9'd100);
        5: configure(16'd2048, 9'd0, 9'd511);
        6: configure(16'd1280, 9'd511, 9'd17);
        default: configure(16'($urandom_range(512, 16384)), 9'($urandom_range(1, 256)),
                           9'($urandom_range(1, 256)));
      endcase
      no_gaps = ($urandom_range(3) == 0);
      for (n = 0; n < 183; n++) random_request();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("[grid_line_of_sight_unit] OK");
    else $display("[grid_line_of_sight_unit] ERROR");
    $finish;
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin
    #60_000_000;
    $display("[grid_line_of_sight_unit] ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/gls_pkg.sv
hdl/grid_line_of_sight_unit.sv
sim/gls_result_checker.sv
sim/tb_grid_line_of_sight_unit.sv
